@@ hdl/apsa_pkg.sv @@
`default_nettype none
package apsa_pkg;

	// field and register widths
	localparam int DataW    = 16;
	localparam int ErrW     = DataW + 1;
	localparam int SumW     = 32;
	localparam int KpW      = 15;
	localparam int IgW      = 16;
	localparam int LimW     = 15;
	localparam int KpFrac   = 12;
	localparam int IgFrac   = 20;
	localparam int CfgIdxW  = 4;
	localparam int CfgDataW = 16;

	// register indexes on the configuration channel
	typedef enum logic [CfgIdxW-1:0] {
		REG_PITCH_KP       = 4'd0,
		REG_PITCH_IG       = 4'd1,
		REG_ROLL_KP        = 4'd2,
		REG_ROLL_IG        = 4'd3,
		REG_PITCH_RATE_DMP = 4'd4,
		REG_PITCH_ANGLE_FB = 4'd5,
		REG_ROLL_ANGLE_FB  = 4'd6,
		REG_SAT_LIMIT      = 4'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [KpW-1:0]  pitch_kp;
		logic [IgW-1:0]  pitch_ig;
		logic [KpW-1:0]  roll_kp;
		logic [IgW-1:0]  roll_ig;
		logic [KpW-1:0]  pitch_rate_dmp;
		logic [KpW-1:0]  pitch_angle_fb;
		logic [KpW-1:0]  roll_angle_fb;
		logic [LimW-1:0] sat_limit;
	} cfg_t;

	localparam cfg_t CfgReset = '{
		pitch_kp:       15'd8192,
		pitch_ig:       16'd1049,
		roll_kp:        15'd8192,
		roll_ig:        16'd1049,
		pitch_rate_dmp: 15'd1229,
		pitch_angle_fb: 15'd819,
		roll_angle_fb:  15'd819,
		sat_limit:      15'd1430
	};

	// stage load strobes shared by the axis loops
	typedef struct packed {
		logic ld_s2;
		logic upd_sum;
		logic ld_s3;
	} pipe_ctl_t;

endpackage
`default_nettype wire

@@ hdl/apsa_if.sv @@
`default_nettype none
// one control tick request: targets, throttle and measurements
interface apsa_tick_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [apsa_pkg::DataW-1:0]     pitch_target;
	logic signed [apsa_pkg::DataW-1:0]     roll_target;
	logic signed [apsa_pkg::DataW-1:0]     throttle_demand;
	logic signed [apsa_pkg::DataW-1:0]     pitch_angle;
	logic signed [apsa_pkg::DataW-1:0]     roll_angle;
	logic signed [apsa_pkg::DataW-1:0]     pitch_rate;

	modport source (output valid, pitch_target, roll_target, throttle_demand,
		pitch_angle, roll_angle, pitch_rate, input ready);
	modport sink (input valid, pitch_target, roll_target, throttle_demand,
		pitch_angle, roll_angle, pitch_rate, output ready);
endinterface

// actuator command request
interface apsa_cmd_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [apsa_pkg::DataW-1:0]     elevator_cmd;
	logic signed [apsa_pkg::DataW-1:0]     aileron_cmd;
	logic signed [apsa_pkg::DataW-1:0]     throttle_cmd;

	modport source (output valid, elevator_cmd, aileron_cmd, throttle_cmd, input ready);
	modport sink (input valid, elevator_cmd, aileron_cmd, throttle_cmd, output ready);
endinterface

// register write request
interface apsa_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [apsa_pkg::CfgIdxW-1:0]          index;
	logic [apsa_pkg::CfgDataW-1:0]         wdata;

	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

@@ hdl/attitude_pi_with_stability_augment_unit.sv @@
`default_nettype none
// Pitch/roll PI attitude controller with stability augmentation. One tick
// request on "tick" gives one command request on "cmd": elevator and aileron
// are the clamped PI outputs minus angle feedback (elevator also minus rate
// damping), saturated to 16 bits; throttle passes through. A tick passes the
// input register, product stage, integral product stage and output register.
// A new tick is taken every cycle unless "cmd" stalls; the error-sum register
// sets the rate; its add-and-saturate is combinational. The error sums reset
// to zero with no clearing pass. Register writes on "cfg" are always taken
// and apply from the next cycle; write them only while no tick is in flight.
module attitude_pi_with_stability_augment_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	apsa_tick_if.sink  tick,
	apsa_cmd_if.source cmd,
	apsa_cfg_if.sink   cfg
);

	localparam int DataW = apsa_pkg::DataW;
	localparam int FFull = 2 * DataW;
	localparam int FW    = FFull - apsa_pkg::KpFrac;
	localparam int CmdW  = FW + 2;

	apsa_pkg::cfg_t      regs;
	apsa_pkg::pipe_ctl_t ctl;

	logic v_s1, v_s2, v_s3, out_v_q;
	logic s1_free, s2_free, s3_free, out_free;

	logic signed [DataW-1:0] pitch_t_s1, roll_t_s1, thr_s1, pitch_a_s1, roll_a_s1, rate_s1;
	logic signed [DataW-1:0] thr_s2, thr_s3;
	logic signed [FFull-1:0] rate_prod, pitch_prod, roll_prod;
	logic signed [FW-1:0]    rate_fb_s2, pitch_fb_s2, roll_fb_s2;
	logic signed [FW-1:0]    rate_fb_s3, pitch_fb_s3, roll_fb_s3;
	logic signed [DataW-1:0] pitch_pi, roll_pi;
	logic signed [CmdW-1:0]  elev_raw, ail_raw;
	logic signed [DataW-1:0] elev_q, ail_q, thr_q;

	function automatic logic signed [DataW-1:0] sat16(input logic signed [CmdW-1:0] x);
		logic signed [CmdW-1:0] hi;
		logic signed [CmdW-1:0] lo;
		hi = {{(CmdW - DataW + 1){1'b0}}, {(DataW-1){1'b1}}};
		lo = {{(CmdW - DataW + 1){1'b1}}, {(DataW-1){1'b0}}};
		if (x > hi) begin
			return hi[DataW-1:0];
		end else if (x < lo) begin
			return lo[DataW-1:0];
		end
		return x[DataW-1:0];
	endfunction

	apsa_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// stage flow: a stage loads when empty or when it drains forward
	assign out_free   = !out_v_q || cmd.ready;
	assign s3_free    = !v_s3 || out_free;
	assign s2_free    = !v_s2 || s3_free;
	assign s1_free    = !v_s1 || s2_free;
	assign tick.ready = s1_free;

	assign ctl.ld_s2   = s2_free;
	assign ctl.upd_sum = s2_free && v_s1;
	assign ctl.ld_s3   = s3_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s1_free) begin
				v_s1 <= tick.valid;
			end
			if (s2_free) begin
				v_s2 <= v_s1;
			end
			if (s3_free) begin
				v_s3 <= v_s2;
			end
			if (out_free) begin
				out_v_q <= v_s3;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (s1_free) begin
			pitch_t_s1 <= tick.pitch_target;
			roll_t_s1  <= tick.roll_target;
			thr_s1     <= tick.throttle_demand;
			pitch_a_s1 <= tick.pitch_angle;
			roll_a_s1  <= tick.roll_angle;
			rate_s1    <= tick.pitch_rate;
		end
	end

	apsa_axis u_pitch (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.target (pitch_t_s1),
		.angle  (pitch_a_s1),
		.kp     (regs.pitch_kp),
		.ig     (regs.pitch_ig),
		.lim    (regs.sat_limit),
		.pi     (pitch_pi)
	);

	apsa_axis u_roll (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.target (roll_t_s1),
		.angle  (roll_a_s1),
		.kp     (regs.roll_kp),
		.ig     (regs.roll_ig),
		.lim    (regs.sat_limit),
		.pi     (roll_pi)
	);

	// augmentation products
	assign rate_prod  = $signed({1'b0, regs.pitch_rate_dmp}) * rate_s1;
	assign pitch_prod = $signed({1'b0, regs.pitch_angle_fb}) * pitch_a_s1;
	assign roll_prod  = $signed({1'b0, regs.roll_angle_fb}) * roll_a_s1;

	always_ff @(posedge clk) begin
		if (s2_free) begin
			rate_fb_s2  <= rate_prod[FFull-1:apsa_pkg::KpFrac];
			pitch_fb_s2 <= pitch_prod[FFull-1:apsa_pkg::KpFrac];
			roll_fb_s2  <= roll_prod[FFull-1:apsa_pkg::KpFrac];
			thr_s2      <= thr_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_free) begin
			rate_fb_s3  <= rate_fb_s2;
			pitch_fb_s3 <= pitch_fb_s2;
			roll_fb_s3  <= roll_fb_s2;
			thr_s3      <= thr_s2;
		end
	end

	// command mix and 16-bit saturation
	assign elev_raw = {{(CmdW - DataW){pitch_pi[DataW-1]}}, pitch_pi}
		- {{(CmdW - FW){rate_fb_s3[FW-1]}}, rate_fb_s3}
		- {{(CmdW - FW){pitch_fb_s3[FW-1]}}, pitch_fb_s3};
	assign ail_raw = {{(CmdW - DataW){roll_pi[DataW-1]}}, roll_pi}
		- {{(CmdW - FW){roll_fb_s3[FW-1]}}, roll_fb_s3};

	always_ff @(posedge clk) begin
		if (out_free) begin
			elev_q <= sat16(elev_raw);
			ail_q  <= sat16(ail_raw);
			thr_q  <= thr_s3;
		end
	end

	assign cmd.valid        = out_v_q;
	assign cmd.elevator_cmd = elev_q;
	assign cmd.aileron_cmd  = ail_q;
	assign cmd.throttle_cmd = thr_q;

	// ready drops only with every stage full and the output stalled
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!tick.ready |-> (v_s1 && v_s2 && v_s3 && out_v_q && !cmd.ready))
		else $error("tick refused with a free stage");

	// a stalled last stage keeps its tick
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !out_free) |=> v_s3)
		else $error("tick dropped from last stage");

	// accepted tick lands in the input register
	a_tick_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(tick.valid && tick.ready) |=> (v_s1 && thr_s1 == $past(tick.throttle_demand)))
		else $error("accepted tick not captured");

endmodule
`default_nettype wire

@@ hdl/apsa_cfg_regs.sv @@
`default_nettype none
module apsa_cfg_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	apsa_cfg_if.sink           cfg,
	output apsa_pkg::cfg_t     regs
);

	apsa_pkg::cfg_t regs_q;

	// writes are always taken; unknown indexes drop
	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= apsa_pkg::CfgReset;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				apsa_pkg::REG_PITCH_KP: begin
					regs_q.pitch_kp <= cfg.wdata[apsa_pkg::KpW-1:0];
				end
				apsa_pkg::REG_PITCH_IG: begin
					regs_q.pitch_ig <= cfg.wdata[apsa_pkg::IgW-1:0];
				end
				apsa_pkg::REG_ROLL_KP: begin
					regs_q.roll_kp <= cfg.wdata[apsa_pkg::KpW-1:0];
				end
				apsa_pkg::REG_ROLL_IG: begin
					regs_q.roll_ig <= cfg.wdata[apsa_pkg::IgW-1:0];
				end
				apsa_pkg::REG_PITCH_RATE_DMP: begin
					regs_q.pitch_rate_dmp <= cfg.wdata[apsa_pkg::KpW-1:0];
				end
				apsa_pkg::REG_PITCH_ANGLE_FB: begin
					regs_q.pitch_angle_fb <= cfg.wdata[apsa_pkg::KpW-1:0];
				end
				apsa_pkg::REG_ROLL_ANGLE_FB: begin
					regs_q.roll_angle_fb <= cfg.wdata[apsa_pkg::KpW-1:0];
				end
				apsa_pkg::REG_SAT_LIMIT: begin
					regs_q.sat_limit <= cfg.wdata[apsa_pkg::LimW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ hdl/apsa_axis.sv @@
`default_nettype none
module apsa_axis (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire apsa_pkg::pipe_ctl_t                 ctl,
	input  wire logic signed [apsa_pkg::DataW-1:0]   target,
	input  wire logic signed [apsa_pkg::DataW-1:0]   angle,
	input  wire logic [apsa_pkg::KpW-1:0]            kp,
	input  wire logic [apsa_pkg::IgW-1:0]            ig,
	input  wire logic [apsa_pkg::LimW-1:0]           lim,
	output logic signed [apsa_pkg::DataW-1:0]        pi
);

	localparam int ErrW  = apsa_pkg::ErrW;
	localparam int SumW  = apsa_pkg::SumW;
	localparam int PFull = apsa_pkg::KpW + 1 + ErrW;
	localparam int PW    = PFull - apsa_pkg::KpFrac;
	localparam int IFull = apsa_pkg::IgW + 1 + SumW;
	localparam int IW    = IFull - apsa_pkg::IgFrac;
	localparam int PiW   = ((IW > PW) ? IW : PW) + 1;
	localparam int DataW = apsa_pkg::DataW;
	localparam int LimW  = apsa_pkg::LimW;

	logic signed [SumW-1:0]  sum_q;
	logic signed [ErrW-1:0]  err;
	logic signed [SumW:0]    sum_wide;
	logic signed [SumW-1:0]  sum_next;
	logic signed [PFull-1:0] p_full;
	logic signed [SumW-1:0]  sum_s2;
	logic signed [PW-1:0]    p_s2;
	logic signed [IFull-1:0] i_full;
	logic signed [PW-1:0]    p_s3;
	logic signed [IW-1:0]    i_s3;
	logic signed [PiW-1:0]   pi_raw;
	logic signed [PiW-1:0]   lim_pos;
	logic signed [PiW-1:0]   lim_neg;

	// error and saturating error sum
	assign err      = {target[DataW-1], target} - {angle[DataW-1], angle};
	assign sum_wide = {sum_q[SumW-1], sum_q} + {{(SumW + 1 - ErrW){err[ErrW-1]}}, err};

	always_comb begin
		if (sum_wide[SumW] != sum_wide[SumW-1]) begin
			sum_next = sum_wide[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
		end else begin
			sum_next = sum_wide[SumW-1:0];
		end
	end

	// proportional product, floor by dropping fraction bits
	assign p_full = $signed({1'b0, kp}) * err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.upd_sum) begin
			sum_q <= sum_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			sum_s2 <= sum_next;
			p_s2   <= p_full[PFull-1:apsa_pkg::KpFrac];
		end
	end

	// integral product on the updated sum
	assign i_full = $signed({1'b0, ig}) * sum_s2;

	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			p_s3 <= p_s2;
			i_s3 <= i_full[IFull-1:apsa_pkg::IgFrac];
		end
	end

	// PI sum and symmetric clamp
	assign pi_raw  = {{(PiW - PW){p_s3[PW-1]}}, p_s3} + {{(PiW - IW){i_s3[IW-1]}}, i_s3};
	assign lim_pos = {{(PiW - LimW){1'b0}}, lim};
	assign lim_neg = -lim_pos;

	always_comb begin
		if (pi_raw > lim_pos) begin
			pi = lim_pos[DataW-1:0];
		end else if (pi_raw < lim_neg) begin
			pi = lim_neg[DataW-1:0];
		end else begin
			pi = pi_raw[DataW-1:0];
		end
	end

	// sum moves only with a tick leaving the input stage
	a_sum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.upd_sum |=> $stable(sum_q))
		else $error("error sum changed without a tick");

	// clamped PI output stays inside the limit
	a_pi_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		($signed({{(PiW - DataW){pi[DataW-1]}}, pi}) <= lim_pos)
		&& ($signed({{(PiW - DataW){pi[DataW-1]}}, pi}) >= lim_neg))
		else $error("PI output outside saturation limit");

endmodule
`default_nettype wire
